/* design/epcg_pkg.sv */
// ----------------------------------------------------------------------------
// epcg_pkg
// Shared constants, types and the quarter-wave sine table for the
// equal-power crossfade gain engine.
// ----------------------------------------------------------------------------
package epcg_pkg;

  // Sizing
  localparam int FRAME_COUNT_WIDTH = 16;
  localparam int SINE_TABLE_DEPTH  = 256;
  localparam int LEVEL_FRAC_BITS   = 16;

  localparam int FRAME_W   = FRAME_COUNT_WIDTH;
  localparam int FRAC_W    = LEVEL_FRAC_BITS;
  localparam int T_W       = FRAC_W + 1;                  // t, sine, cosine
  localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam int DUR_W     = 16;
  localparam int LVL_W     = 17;                          // Q1.16 levels
  localparam int Q16       = 16;
  localparam int GAIN_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Divider: numerator must hold elapsed<<FRAC_W and elapsed*2*DEPTH+length
  localparam int DIV_W = (FRAME_W + FRAC_W > FRAME_W + DEPTH_LOG + 2) ?
                         (FRAME_W + FRAC_W) : (FRAME_W + DEPTH_LOG + 2);
  localparam int DVS_W = FRAME_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Shared multiplier
  localparam int MA_W   = 19;
  localparam int MB_W   = (T_W > LVL_W) ? T_W : LVL_W;
  localparam int PROD_W = MA_W + MB_W;

  localparam logic [LVL_W-1:0] MASTER_RESET = LVL_W'(65536);
  localparam logic [LVL_W-1:0] BUS_RESET    = LVL_W'(58982);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUS    = CFG_IDX_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_START_RES, ST_IDLE_RES, ST_DIVT, ST_DIVT_WAIT, ST_DIVI,
    ST_DIVI_WAIT, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_M9, ST_M10, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE, MS_START_ONEMT, MS_END_T, MS_LVL_W, MS_MV_BUS, MS_V_RATE, MS_V_LVL
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_ACC, WB_LERP, WB_LVL, WB_V, WB_GAIN
  } wb_sel_t;

  typedef enum logic [1:0] {
    RES_NONE, RES_START, RES_IDLE, RES_TICK
  } res_sel_t;

  typedef struct packed {
    logic     load_fade;
    logic     step_elapsed;
    logic     div_start;
    logic     div_sel_idx;
    logic     cap_t;
    logic     cap_idx;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     trk;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic active;
    logic div_done;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic             kind;
    logic [DUR_W-1:0] duration_frames;
    logic             has_out_track;
    logic             has_in_track;
    logic [LVL_W-1:0] out_start_level;
    logic [LVL_W-1:0] out_end_level;
    logic [LVL_W-1:0] in_start_level;
    logic [LVL_W-1:0] in_end_level;
    logic [LVL_W-1:0] out_clip_rate;
    logic [LVL_W-1:0] in_clip_rate;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] out_gain;
    logic [GAIN_W-1:0] in_gain;
    logic              out_valid;
    logic              in_valid;
    logic              stop_out;
    logic              fade_done;
    logic              fading;
  } out_item_t;

  // Quarter-wave sine table, Q30 Taylor series rounded to FRAC_W bits
  typedef logic [T_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[k];
        if (k[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      e = ((longint'(unsigned'(sum)) << FRAC_W) + (64'd1 << 29)) >> 30;
      tab[i] = e[T_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* design/epcg_in_if.sv */
// ----------------------------------------------------------------------------
// epcg_in_if
// Input channel: tick and fade-start beats.
// ----------------------------------------------------------------------------
interface epcg_in_if;
  import epcg_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [DUR_W-1:0] duration_frames;
  logic             has_out_track;
  logic             has_in_track;
  logic [LVL_W-1:0] out_start_level;
  logic [LVL_W-1:0] out_end_level;
  logic [LVL_W-1:0] in_start_level;
  logic [LVL_W-1:0] in_end_level;
  logic [LVL_W-1:0] out_clip_rate;
  logic [LVL_W-1:0] in_clip_rate;

  modport source (output valid, kind, duration_frames, has_out_track, has_in_track,
                  out_start_level, out_end_level, in_start_level, in_end_level,
                  out_clip_rate, in_clip_rate, input ready);
  modport sink   (input valid, kind, duration_frames, has_out_track, has_in_track,
                  out_start_level, out_end_level, in_start_level, in_end_level,
                  out_clip_rate, in_clip_rate, output ready);
endinterface

/* design/epcg_out_if.sv */
// ----------------------------------------------------------------------------
// epcg_out_if
// Result channel: one gain beat per input beat.
// ----------------------------------------------------------------------------
interface epcg_out_if;
  import epcg_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] out_gain;
  logic [GAIN_W-1:0] in_gain;
  logic              out_valid;
  logic              in_valid;
  logic              stop_out;
  logic              fade_done;
  logic              fading;

  modport source (output valid, out_gain, in_gain, out_valid, in_valid, stop_out,
                  fade_done, fading, input ready);
  modport sink   (input valid, out_gain, in_gain, out_valid, in_valid, stop_out,
                  fade_done, fading, output ready);
endinterface

/* design/epcg_cfg_if.sv */
// ----------------------------------------------------------------------------
// epcg_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface epcg_cfg_if;
  import epcg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LVL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/epcg_divider.sv */
// ----------------------------------------------------------------------------
// epcg_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epcg_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [epcg_pkg::DIV_W-1:0] dividend,
  input  logic [epcg_pkg::DVS_W-1:0] divisor,
  output logic [epcg_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import epcg_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;

  // One shift-and-subtract step
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = DCNT_W'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* design/epcg_datapath.sv */
// ----------------------------------------------------------------------------
// epcg_datapath
// Fade state, config registers, shared divider and multiplier, result
// register. Driven step by step by the controller.
// ----------------------------------------------------------------------------
module epcg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  epcg_pkg::cmd_t                cmd,
  output epcg_pkg::stat_t               stat,
  input  epcg_pkg::in_item_t            in_item,
  input  logic                          cfg_wr,
  input  logic [epcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [epcg_pkg::LVL_W-1:0]    cfg_data,
  input  logic                          out_pop,
  output logic                          out_full,
  output epcg_pkg::out_item_t           out_item
);
  import epcg_pkg::*;

  localparam logic [T_W-1:0]   ONE_T   = T_W'(1) << FRAC_W;
  localparam logic [PROD_W:0]  HALF_T  = (PROD_W + 1)'(1) << (FRAC_W - 1);
  localparam logic [PROD_W:0]  HALF_16 = (PROD_W + 1)'(1) << (Q16 - 1);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << Q16;
  localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(SINE_TABLE_DEPTH);

  // Config and fade state
  logic [LVL_W-1:0]   mv_r, bus_r;
  logic               active_r;
  logic [FRAME_W-1:0] elapsed_r;
  logic [FRAME_W-1:0] len_r;
  logic [1:0]         present_r;
  logic [LVL_W-1:0]   ep_r [4];
  logic [LVL_W-1:0]   rate_r [2];

  // Working registers
  logic [T_W-1:0]     t_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W:0]    acc_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [MA_W-1:0]    v_r;
  logic [GAIN_W-1:0]  gain_r [2];
  logic               out_full_r;
  out_item_t          out_item_r;

  // Divider
  logic [DIV_W-1:0]   div_num;
  logic [DVS_W-1:0]   div_den;
  logic [DIV_W-1:0]   div_q;
  logic               div_done;

  assign div_num = cmd.div_sel_idx ?
                   (DIV_W'(elapsed_r) * DIV_W'(2 * SINE_TABLE_DEPTH) + DIV_W'(len_r)) :
                   (DIV_W'(elapsed_r) << FRAC_W);
  assign div_den = cmd.div_sel_idx ? {len_r, 1'b0} : DVS_W'(len_r);

  epcg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  // Multiplier operand selection
  logic [LVL_W-1:0]  trk_start, trk_end, trk_rate;
  logic [T_W-1:0]    trk_w;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod_nxt;

  assign trk_start = cmd.trk ? ep_r[2] : ep_r[0];
  assign trk_end   = cmd.trk ? ep_r[3] : ep_r[1];
  assign trk_rate  = rate_r[cmd.trk];
  assign trk_w     = cmd.trk ? SINE_TAB[idx_r] : SINE_TAB[DEPTH_I - idx_r];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_START_ONEMT: begin mul_a = MA_W'(trk_start); mul_b = MB_W'(ONE_T - t_r); end
      MS_END_T:       begin mul_a = MA_W'(trk_end);   mul_b = MB_W'(t_r);         end
      MS_LVL_W:       begin mul_a = MA_W'(lvl_r);     mul_b = MB_W'(trk_w);       end
      MS_MV_BUS:      begin mul_a = MA_W'(mv_r);      mul_b = MB_W'(bus_r);       end
      MS_V_RATE:      begin mul_a = v_r;              mul_b = MB_W'(trk_rate);    end
      MS_V_LVL:       begin mul_a = v_r;              mul_b = MB_W'(lvl_r);       end
      default:        begin mul_a = '0;               mul_b = '0;                 end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Writeback arithmetic
  logic [PROD_W:0]   lerp_sum, rnd_t, rnd_16;
  logic [LVL_W-1:0]  v_clamp;
  logic [23:0]       gain_sum;
  logic [GAIN_W-1:0] gain_new;

  assign lerp_sum = acc_r + {1'b0, prod_r} + HALF_T;
  assign rnd_t    = {1'b0, prod_r} + HALF_T;
  assign rnd_16   = {1'b0, prod_r} + HALF_16;
  assign v_clamp  = ((rnd_16 >> Q16) > (PROD_W + 1)'(LVL_ONE)) ? LVL_ONE :
                    LVL_W'(rnd_16 >> Q16);
  assign gain_sum = ({7'd0, v_clamp} << 8) - {7'd0, v_clamp} + 24'd32768;
  assign gain_new = gain_sum[23:16];

  // Clamped divider results
  logic [T_W-1:0]   t_clamp;
  logic [IDX_W-1:0] idx_clamp;
  assign t_clamp   = (div_q > DIV_W'(ONE_T)) ? ONE_T : T_W'(div_q);
  assign idx_clamp = (div_q > DIV_W'(SINE_TABLE_DEPTH)) ? DEPTH_I : IDX_W'(div_q);

  logic t_done;
  assign t_done = (t_r >= ONE_T);

  // Config and fade state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= MASTER_RESET;
      bus_r     <= BUS_RESET;
      active_r  <= 1'b0;
      elapsed_r <= '0;
      len_r     <= '0;
      present_r <= '0;
      for (int i = 0; i < 4; i++) ep_r[i] <= '0;
      for (int i = 0; i < 2; i++) rate_r[i] <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_MASTER: mv_r  <= cfg_data;
          CFG_BUS:    bus_r <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.load_fade) begin
        len_r     <= FRAME_W'(in_item.duration_frames);
        present_r <= {in_item.has_in_track, in_item.has_out_track};
        ep_r[0]   <= in_item.out_start_level;
        ep_r[1]   <= in_item.out_end_level;
        ep_r[2]   <= in_item.in_start_level;
        ep_r[3]   <= in_item.in_end_level;
        rate_r[0] <= in_item.out_clip_rate;
        rate_r[1] <= in_item.in_clip_rate;
        elapsed_r <= '0;
        active_r  <= (FRAME_W'(in_item.duration_frames) != '0);
      end else if (cmd.step_elapsed) begin
        if (elapsed_r < len_r) elapsed_r <= FRAME_W'(elapsed_r + 1'b1);
      end else if (cmd.res_sel == RES_TICK && t_done) begin
        // Fade finished: back to idle with cleared state
        active_r  <= 1'b0;
        elapsed_r <= '0;
        len_r     <= '0;
        present_r <= '0;
        for (int i = 0; i < 4; i++) ep_r[i] <= '0;
        for (int i = 0; i < 2; i++) rate_r[i] <= '0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_t)   t_r   <= t_clamp;
    if (cmd.cap_idx) idx_r <= idx_clamp;
    if (cmd.mul_sel != MS_NONE) prod_r <= prod_nxt;
    case (cmd.wb_sel)
      WB_ACC:  acc_r         <= {1'b0, prod_r};
      WB_LERP: lvl_r         <= LVL_W'(lerp_sum >> FRAC_W);
      WB_LVL:  lvl_r         <= LVL_W'(rnd_t >> FRAC_W);
      WB_V:    v_r           <= MA_W'(rnd_16 >> Q16);
      WB_GAIN: gain_r[cmd.trk] <= gain_new;
      default: ;
    endcase
  end

  // Result register
  out_item_t res_nxt;
  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_START: res_nxt.fading = active_r;
      RES_TICK: begin
        res_nxt.out_gain  = present_r[0] ? gain_r[0] : '0;
        res_nxt.in_gain   = present_r[1] ? gain_r[1] : '0;
        res_nxt.out_valid = present_r[0];
        res_nxt.in_valid  = present_r[1];
        res_nxt.stop_out  = present_r[0] & t_done;
        res_nxt.fade_done = t_done;
        res_nxt.fading    = ~t_done;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (cmd.res_sel != RES_NONE) begin
      out_full_r <= 1'b1;
    end else if (out_pop) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_sel != RES_NONE) out_item_r <= res_nxt;
  end

  assign out_full      = out_full_r;
  assign out_item      = out_item_r;
  assign stat.kind     = in_item.kind;
  assign stat.active   = active_r;
  assign stat.div_done = div_done;
  assign stat.out_full = out_full_r;

endmodule

/* design/epcg_controller.sv */
// ----------------------------------------------------------------------------
// epcg_controller
// Sequencer: accepts a beat; for an active tick runs the two divides and the
// per-track multiply steps; hands each result to the output register.
// ----------------------------------------------------------------------------
module epcg_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  epcg_pkg::stat_t stat,
  output epcg_pkg::cmd_t  cmd
);
  import epcg_pkg::*;

  state_t state_r, state_nxt;
  logic   trk_r, trk_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    trk_nxt   = trk_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.kind)        state_nxt = ST_START_RES;
          else if (stat.active) state_nxt = ST_DIVT;
          else                  state_nxt = ST_IDLE_RES;
        end
      end
      ST_START_RES: if (!stat.out_full) state_nxt = ST_IDLE;
      ST_IDLE_RES:  if (!stat.out_full) state_nxt = ST_IDLE;
      ST_DIVT:      state_nxt = ST_DIVT_WAIT;
      ST_DIVT_WAIT: if (stat.div_done) state_nxt = ST_DIVI;
      ST_DIVI:      state_nxt = ST_DIVI_WAIT;
      ST_DIVI_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_M1;
          trk_nxt   = 1'b0;
        end
      end
      ST_M1:  state_nxt = ST_M2;
      ST_M2:  state_nxt = ST_M3;
      ST_M3:  state_nxt = ST_M4;
      ST_M4:  state_nxt = ST_M5;
      ST_M5:  state_nxt = ST_M6;
      ST_M6:  state_nxt = ST_M7;
      ST_M7:  state_nxt = ST_M8;
      ST_M8:  state_nxt = ST_M9;
      ST_M9:  state_nxt = ST_M10;
      ST_M10: begin
        if (trk_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_M1;
          trk_nxt   = 1'b1;
        end
      end
      ST_FIN:  if (!stat.out_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.trk  = trk_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.load_fade    = in_valid & stat.kind;
        cmd.step_elapsed = in_valid & ~stat.kind & stat.active;
      end
      ST_START_RES: if (!stat.out_full) cmd.res_sel = RES_START;
      ST_IDLE_RES:  if (!stat.out_full) cmd.res_sel = RES_IDLE;
      ST_DIVT:      cmd.div_start = 1'b1;
      ST_DIVT_WAIT: cmd.cap_t = stat.div_done;
      ST_DIVI: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_idx = 1'b1;
      end
      ST_DIVI_WAIT: cmd.cap_idx = stat.div_done;
      ST_M1:  cmd.mul_sel = MS_START_ONEMT;
      ST_M2: begin
        cmd.mul_sel = MS_END_T;
        cmd.wb_sel  = WB_ACC;
      end
      ST_M3:  cmd.wb_sel = WB_LERP;
      ST_M4:  cmd.mul_sel = MS_LVL_W;
      ST_M5: begin
        cmd.mul_sel = MS_MV_BUS;
        cmd.wb_sel  = WB_LVL;
      end
      ST_M6:  cmd.wb_sel = WB_V;
      ST_M7:  cmd.mul_sel = MS_V_RATE;
      ST_M8:  cmd.wb_sel = WB_V;
      ST_M9:  cmd.mul_sel = MS_V_LVL;
      ST_M10: cmd.wb_sel = WB_GAIN;
      ST_FIN: if (!stat.out_full) cmd.res_sel = RES_TICK;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      trk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      trk_r   <= trk_nxt;
    end
  end

endmodule

/* design/equal_power_crossfade_gain.sv */
// ----------------------------------------------------------------------------
// equal_power_crossfade_gain
// Two-track equal-power fade engine: one gain beat per tick or start beat.
//
//   channel  dir  beat contents
//   in_ch    in   kind, length, track flags, levels, clip rates
//   out_ch   out  out/in gain, valid flags, stop_out, fade_done, fading
//   cfg_ch   in   register index, Q1.16 data (master, music bus)
//
// An active tick is worked by the bit-serial divider (t and table index)
// and the single shared multiplier (10 steps per track). One beat is worked
// at a time; the next is taken as soon as the sequencer is back in idle,
// even while a result waits on out_ch. Reset is synchronous, active low;
// cfg_ch is always ready.
// ----------------------------------------------------------------------------
module equal_power_crossfade_gain (
  input logic        clk,
  input logic        rst_n,
  epcg_in_if.sink    in_ch,
  epcg_out_if.source out_ch,
  epcg_cfg_if.sink   cfg_ch
);
  import epcg_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_full;

  // Pack the input beat
  assign in_item.kind            = in_ch.kind;
  assign in_item.duration_frames = in_ch.duration_frames;
  assign in_item.has_out_track   = in_ch.has_out_track;
  assign in_item.has_in_track    = in_ch.has_in_track;
  assign in_item.out_start_level = in_ch.out_start_level;
  assign in_item.out_end_level   = in_ch.out_end_level;
  assign in_item.in_start_level  = in_ch.in_start_level;
  assign in_item.in_end_level    = in_ch.in_end_level;
  assign in_item.out_clip_rate   = in_ch.out_clip_rate;
  assign in_item.in_clip_rate    = in_ch.in_clip_rate;

  assign cfg_ch.ready = 1'b1;

  epcg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  epcg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_wr    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_pop   (out_ch.valid & out_ch.ready),
    .out_full  (out_full),
    .out_item  (out_item)
  );

  // Unpack the result beat
  assign out_ch.valid     = out_full;
  assign out_ch.out_gain  = out_item.out_gain;
  assign out_ch.in_gain   = out_item.in_gain;
  assign out_ch.out_valid = out_item.out_valid;
  assign out_ch.in_valid  = out_item.in_valid;
  assign out_ch.stop_out  = out_item.stop_out;
  assign out_ch.fade_done = out_item.fade_done;
  assign out_ch.fading    = out_item.fading;

endmodule

/* design/epcg_checker.sv */
// ----------------------------------------------------------------------------
// epcg_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module epcg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       o_valid,
  input logic       o_ready,
  input logic [7:0] o_out_gain,
  input logic [7:0] o_in_gain,
  input logic       o_out_valid,
  input logic       o_in_valid,
  input logic       o_stop_out,
  input logic       o_fade_done,
  input logic       o_fading
);

  // Stalled beat holds its gains, stop_out, fade_done and fading
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_out_gain) && $stable(o_in_gain)
      && $stable(o_stop_out) && $stable(o_fade_done) && $stable(o_fading))
    else $error("result beat changed while stalled");

  // A finished fade is no longer fading
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_fade_done |-> !o_fading)
    else $error("fade_done with fading set");

  // Stop only at fade end and only for a present outgoing track
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_stop_out |-> o_fade_done && o_out_valid)
    else $error("stop_out without fade end");

  // Non-zero gain only on a present track
  a_gain: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_out_gain == 8'd0 || o_out_valid) && (o_in_gain == 8'd0 || o_in_valid))
    else $error("gain on an absent track");

endmodule

bind equal_power_crossfade_gain epcg_checker u_epcg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .o_valid     (out_ch.valid),
  .o_ready     (out_ch.ready),
  .o_out_gain  (out_ch.out_gain),
  .o_in_gain   (out_ch.in_gain),
  .o_out_valid (out_ch.out_valid),
  .o_in_valid  (out_ch.in_valid),
  .o_stop_out  (out_ch.stop_out),
  .o_fade_done (out_ch.fade_done),
  .o_fading    (out_ch.fading)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for equal_power_crossfade_gain. A directed table of
// beats covers idle ticks, zero-length starts, track presence, level and
// rate extremes and fades cut short; random fade sequences follow under
// several master/bus settings. Each gain beat is checked against its row's
// want or a local engine model; both channels idle at random but in phase 1.
// ----------------------------------------------------------------------------
module testbench;
  import epcg_pkg::*;

  localparam int  MAX_SHOWN   = 10;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  RAND_BEATS  = 1700;
  localparam int  N_PHASES    = 5;
  localparam int  QDEPTH      = 256;
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  epcg_in_if  in_ch ();
  epcg_out_if out_ch ();
  epcg_cfg_if cfg_ch ();

  equal_power_crossfade_gain dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the engine state
  longint unsigned sine_q [0:QDEPTH];
  longint unsigned master_lvl;
  longint unsigned bus_lvl;
  bit              fade_on;
  longint unsigned frames_done;
  longint unsigned frames_total;
  bit [1:0]        tracks;
  longint unsigned lvl_ends [4];
  longint unsigned rate_q [2];

  stim_row_t rows [$];
  out_item_t gain_expect_q [$];
  int        mismatches;
  int        cycles;
  bit        idle_on;
  bit        row_typed;
  out_item_t row_want;

  // Quarter-wave table, Q30 Taylor series rounded to Q16
  function automatic void fill_sine();
    longint unsigned x, x2, term;
    longint          acc;
    for (int i = 0; i <= QDEPTH; i++) begin
      x    = (64'd1686629713 * 64'(i)) / QDEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        acc  = k[0] ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      sine_q[i] = ((64'(acc) << 16) + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic logic [7:0] track_gain_calc(longint unsigned s, longint unsigned e,
                                                 longint unsigned t, longint unsigned w,
                                                 longint unsigned rate);
    longint unsigned lvl, v;
    lvl = (s * (64'd65536 - t) + e * t + 64'd32768) >> 16;
    lvl = (lvl * w + 64'd32768) >> 16;
    v   = qmul(qmul(qmul(master_lvl, bus_lvl), rate), lvl);
    if (v > 64'd65536) v = 64'd65536;
    return 8'((v * 64'd255 + 64'd32768) >> 16);
  endfunction

  // Advance the local engine by one beat and return its gain beat
  function automatic out_item_t fade_step(in_item_t b);
    out_item_t       r;
    longint unsigned t, ix;
    r = '0;
    if (b.kind == KIND_START) begin
      frames_total = 64'(b.duration_frames);
      tracks       = {b.has_in_track, b.has_out_track};
      lvl_ends[0]  = 64'(b.out_start_level);
      lvl_ends[1]  = 64'(b.out_end_level);
      lvl_ends[2]  = 64'(b.in_start_level);
      lvl_ends[3]  = 64'(b.in_end_level);
      rate_q[0]    = 64'(b.out_clip_rate);
      rate_q[1]    = 64'(b.in_clip_rate);
      frames_done  = 0;
      fade_on      = (frames_total != 0);
    end else if (fade_on && frames_total != 0) begin
      if (frames_done < frames_total) frames_done = (frames_done + 1) & 64'hFFFF;
      t = (frames_done << 16) / frames_total;
      if (t > 64'd65536) t = 64'd65536;
      ix = (frames_done * QDEPTH * 2 + frames_total) / (2 * frames_total);
      if (ix > QDEPTH) ix = QDEPTH;
      if (tracks[0]) begin
        r.out_gain  = track_gain_calc(lvl_ends[0], lvl_ends[1], t, sine_q[QDEPTH - ix],
                                      rate_q[0]);
        r.out_valid = 1'b1;
      end
      if (tracks[1]) begin
        r.in_gain  = track_gain_calc(lvl_ends[2], lvl_ends[3], t, sine_q[ix], rate_q[1]);
        r.in_valid = 1'b1;
      end
      if (t >= 64'd65536) begin
        r.stop_out   = tracks[0];
        r.fade_done  = 1'b1;
        fade_on      = 1'b0;
        frames_done  = 0;
        frames_total = 0;
        tracks       = '0;
        lvl_ends     = '{default: 0};
        rate_q       = '{default: 0};
      end
    end else begin
      fade_on = 1'b0;
    end
    r.fading = fade_on;
    return r;
  endfunction

  function automatic in_item_t mk_beat(logic k, int unsigned dur, logic ho, logic hi,
                                       int unsigned os, int unsigned oe, int unsigned is,
                                       int unsigned ie, int unsigned orate,
                                       int unsigned irate);
    in_item_t b;
    b.kind = k;
    b.duration_frames = DUR_W'(dur);
    b.has_out_track = ho;
    b.has_in_track = hi;
    b.out_start_level = LVL_W'(os);
    b.out_end_level = LVL_W'(oe);
    b.in_start_level = LVL_W'(is);
    b.in_end_level = LVL_W'(ie);
    b.out_clip_rate = LVL_W'(orate);
    b.in_clip_rate = LVL_W'(irate);
    return b;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(in_item_t b, bit typed, out_item_t want);
    stim_row_t r;
    r.beat  = b;
    r.typed = typed;
    r.want  = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic int unsigned rand_level();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(65536);
    if (pick < 85) return 65536;
    return $urandom_range(131071);
  endfunction

  function automatic in_item_t rand_start(int unsigned dur);
    return mk_beat(KIND_START, dur, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   rand_level(), rand_level(), rand_level(), rand_level(), rand_level(),
                   rand_level());
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t b;
    b = rand_start($urandom_range(65535));
    b.kind = KIND_TICK;
    return b;
  endfunction

  // Input beat driver: payload changes at the falling edge
  task automatic send_beat(in_item_t b, bit typed, out_item_t want);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    {in_ch.kind, in_ch.duration_frames, in_ch.has_out_track, in_ch.has_in_track,
     in_ch.out_start_level, in_ch.out_end_level, in_ch.in_start_level,
     in_ch.in_end_level, in_ch.out_clip_rate, in_ch.in_clip_rate} = b;
    row_typed   = typed;
    row_want    = want;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    in_ch.valid  = 1'b0;
    cfg_ch.index = idx;
    cfg_ch.data  = LVL_W'(val);
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait for every gain beat, then let the engine settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (gain_expect_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Input monitor: predict on every accepted beat
  always @(posedge clk) begin
    out_item_t p;
    in_item_t  b;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      b = {in_ch.kind, in_ch.duration_frames, in_ch.has_out_track, in_ch.has_in_track,
           in_ch.out_start_level, in_ch.out_end_level, in_ch.in_start_level,
           in_ch.in_end_level, in_ch.out_clip_rate, in_ch.in_clip_rate};
      p = fade_step(b);
      gain_expect_q.insert(gain_expect_q.size(), row_typed ? row_want : p);
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_MASTER) master_lvl = 64'(cfg_ch.data);
      else if (cfg_ch.index == CFG_BUS) bus_lvl = 64'(cfg_ch.data);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_gain, out_ch.in_gain, out_ch.out_valid, out_ch.in_valid,
             out_ch.stop_out, out_ch.fade_done, out_ch.fading};
      if (gain_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected gain beat %p", got);
      end else begin
        want = gain_expect_q.pop_front();
        if (got.out_gain !== want.out_gain || got.in_gain !== want.in_gain ||
            got.out_valid !== want.out_valid || got.in_valid !== want.in_valid ||
            got.stop_out !== want.stop_out || got.fade_done !== want.fade_done ||
            got.fading !== want.fading) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("gain beat mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Result back-pressure
  always @(negedge clk)
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    out_item_t   zero_res;
    out_item_t   start_res;
    int unsigned sent;
    int unsigned dur;
    int unsigned n_ticks;
    int unsigned masters [N_PHASES];
    int unsigned buses [N_PHASES];

    in_ch.valid = 1'b0;
    {in_ch.kind, in_ch.duration_frames, in_ch.has_out_track, in_ch.has_in_track,
     in_ch.out_start_level, in_ch.out_end_level, in_ch.in_start_level,
     in_ch.in_end_level, in_ch.out_clip_rate, in_ch.in_clip_rate} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MASTER;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    idle_on      = 1'b1;
    row_typed    = 1'b0;
    row_want     = '0;
    mismatches   = 0;
    cycles       = 0;
    master_lvl   = 65536;
    bus_lvl      = 58982;
    fade_on      = 1'b0;
    frames_done  = 0;
    frames_total = 0;
    tracks       = '0;
    lvl_ends     = '{default: 0};
    rate_q       = '{default: 0};
    fill_sine();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    zero_res  = '0;
    start_res = '0;
    start_res.fading = 1'b1;
    add_row(mk_beat(KIND_TICK, 5, 1, 1, 65536, 0, 0, 65536, 65536, 65536), 1, zero_res);
    add_row(mk_beat(KIND_START, 0, 1, 1, 65536, 0, 0, 65536, 65536, 65536), 1, zero_res);
    add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res);
    // one-frame fade with unity levels: finishes on the first tick
    add_row(mk_beat(KIND_START, 1, 1, 1, 65536, 65536, 65536, 65536, 65536, 65536),
            1, start_res);
    add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res);
    // outgoing track only, levels above one
    add_row(mk_beat(KIND_START, 3, 1, 0, 131071, 131071, 131071, 131071, 131071,
                    131071), 1, start_res);
    repeat (3) add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    // incoming track only
    add_row(mk_beat(KIND_START, 2, 0, 1, 0, 65536, 0, 65536, 32768, 65536), 1, start_res);
    repeat (2) add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    // no tracks at all
    add_row(mk_beat(KIND_START, 2, 0, 0, 65536, 65536, 65536, 65536, 65536, 65536),
            1, start_res);
    repeat (2) add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    // long fade cut short by a restart, then by a zero-length start
    add_row(mk_beat(KIND_START, 65535, 1, 1, 65536, 0, 0, 65536, 65536, 65536),
            1, start_res);
    repeat (2) add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_beat(KIND_START, 4, 1, 1, 0, 0, 0, 0, 0, 0), 1, start_res);
    add_row(mk_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_beat(KIND_START, 0, 1, 1, 65536, 65536, 65536, 65536, 65536, 65536),
            1, zero_res);
    add_row(mk_beat(KIND_TICK, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1, zero_res);
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    drain();

    // Register settings per phase, extremes first
    masters = '{65536, 0, 131071, 65536, 0};
    buses   = '{58982, 65536, 131071, 0, 0};
    masters[3] = $urandom_range(131071);
    buses[4]   = $urandom_range(131071);
    row_want = '0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(CFG_MASTER, masters[ph]);
      write_reg(CFG_BUS, buses[ph]);
      idle_on = (ph != 1);
      sent = 0;
      while (sent < RAND_BEATS / N_PHASES) begin
        if ($urandom_range(99) < 85) begin
          // well-formed fade: start, then ticks up to and a little past the end, or fewer
          dur = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(1, 40);
          send_beat(rand_start(dur), 0, row_want);
          n_ticks = ($urandom_range(9) == 0) ? $urandom_range(dur) : dur + $urandom_range(2);
          for (int k = 0; k < n_ticks; k++) send_beat(rand_tick(), 0, row_want);
          sent += n_ticks + 1;
        end else begin
          // noise: any beat at all, including wide lengths
          if ($urandom_range(1)) send_beat(rand_tick(), 0, row_want);
          else send_beat(rand_start($urandom_range(65535)), 0, row_want);
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0 && gain_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
